/* hw/rtl/rihp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rihp_pkg;

  // Header geometry and magic bytes.
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned POS_W        = $clog2(HEADER_BYTES) + 1;
  localparam logic [7:0]  MAGIC_0      = 8'h4E;
  localparam logic [7:0]  MAGIC_1      = 8'h45;
  localparam logic [7:0]  MAGIC_2      = 8'h53;
  localparam logic [7:0]  MAGIC_3      = 8'h1A;
  localparam logic [7:0]  FORMAT_V1    = 8'h00;
  localparam logic [7:0]  FORMAT_V2    = 8'h08;

  // Byte positions that are kept.
  localparam logic [POS_W-1:0] POS_MAGIC_0 = POS_W'(0);
  localparam logic [POS_W-1:0] POS_MAGIC_1 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_MAGIC_2 = POS_W'(2);
  localparam logic [POS_W-1:0] POS_MAGIC_3 = POS_W'(3);
  localparam logic [POS_W-1:0] POS_PRG     = POS_W'(4);
  localparam logic [POS_W-1:0] POS_CHR     = POS_W'(5);
  localparam logic [POS_W-1:0] POS_FLAGS6  = POS_W'(6);
  localparam logic [POS_W-1:0] POS_FLAGS7  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_RAM     = POS_W'(8);
  localparam logic [POS_W-1:0] POS_FORMAT  = POS_W'(12);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_IDLE    = POS_W'(HEADER_BYTES);

  // Offsets in bytes.
  localparam logic [9:0] HEADER_OFFSET = 10'h010;
  localparam logic [9:0] TRAINER_BYTES = 10'h200;
  localparam logic [20:0] EIGHT_K      = 21'h02000;

  // Flag bits of flags six.
  localparam int unsigned F6_MIRROR  = 0;
  localparam int unsigned F6_BATTERY = 1;
  localparam int unsigned F6_TRAINER = 2;
  localparam int unsigned F6_FOUR    = 3;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_MAGIC  = 2'd1,
    ST_BAD_FORMAT = 2'd2,
    ST_V2_UNSUPP  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MIR_HORIZONTAL = 2'd0,
    MIR_VERTICAL   = 2'd1,
    MIR_FOUR       = 2'd2
  } mirror_t;

  // Captured header content handed from capture to decode.
  typedef struct packed {
    logic       magic_ok;
    logic [7:0] prg_bank_count;
    logic [7:0] chr_bank_count;
    logic [7:0] flags_six;
    logic [7:0] flags_seven;
    logic [7:0] ram_bank_count;
    logic [7:0] format_byte;
  } hdr_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic        pad;
    logic [21:0] chr_offset;
    logic [9:0]  prg_offset;
    logic        chr_is_ram;
    logic [20:0] prg_ram_bytes;
    logic [20:0] chr_bytes;
    logic [21:0] prg_rom_bytes;
    logic        has_trainer;
    logic        has_battery;
    logic [1:0]  mirroring_mode;
    logic [7:0]  mapper_number;
    logic [1:0]  status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

/* hw/rtl/rom_image_header_parser_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// The result item is registered and is valid in the cycle after the sixteenth header byte is taken.
// Throughput: one byte per cycle; a byte is taken whenever the output register is empty
// or is being drained, so while a result waits unread the input side is stalled.
// Reset (synchronous, active low): the parser idles until a byte with the start flag,
// the captured header reads as zero and no result is pending.

module rom_image_header_parser_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] header_byte
  input  wire logic [0:0]                  in_tuser,   // [0] first_byte
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [1:0] status, [9:2] mapper_number, [11:10] mirroring_mode, [12] has_battery,
  // [13] has_trainer, [35:14] prg_rom_bytes, [56:36] chr_bytes, [77:57] prg_ram_bytes,
  // [78] chr_is_ram, [88:79] prg_offset, [110:89] chr_offset, [111] zero
  output logic [rihp_pkg::RESULT_W-1:0]    out_tdata
);

  rihp_pkg::hdr_t hdr;
  logic           last_taken;
  logic           can_load;
  logic           in_accept;

  assign in_tready = can_load;
  assign in_accept = in_tvalid && can_load;

  // Byte position and header capture.
  rihp_capture u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .first_byte  (in_tuser[0]),
    .header_byte (in_tdata),
    .hdr         (hdr),
    .last_taken  (last_taken)
  );

  // Field decode and output register.
  rihp_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .hdr        (hdr),
    .last_taken (last_taken),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/rihp_capture.sv */
`timescale 1ns / 1ps
`default_nettype none

module rihp_capture (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic          first_byte,
  input  wire logic [7:0]    header_byte,
  output rihp_pkg::hdr_t     hdr,
  output logic               last_taken
);

  logic [rihp_pkg::POS_W-1:0] pos_r;
  logic [rihp_pkg::POS_W-1:0] pos_nxt;
  logic [rihp_pkg::POS_W-1:0] pos_eff;
  rihp_pkg::hdr_t             hdr_r;
  rihp_pkg::hdr_t             hdr_nxt;
  logic                       active;

  // A start flag restarts the position; past the header the bytes are ignored.
  assign pos_eff    = first_byte ? '0 : pos_r;
  assign active     = accept && (pos_eff < rihp_pkg::POS_IDLE);
  assign last_taken = active && (pos_eff == rihp_pkg::POS_LAST);
  assign hdr        = hdr_r;

  // Capture the byte at its position.
  always_comb begin
    hdr_nxt = hdr_r;
    pos_nxt = pos_r;
    if (active) begin
      pos_nxt = pos_eff + rihp_pkg::POS_W'(1);
      case (pos_eff)
        rihp_pkg::POS_MAGIC_0: hdr_nxt.magic_ok = (header_byte == rihp_pkg::MAGIC_0);
        rihp_pkg::POS_MAGIC_1: hdr_nxt.magic_ok = hdr_r.magic_ok &&
                                                  (header_byte == rihp_pkg::MAGIC_1);
        rihp_pkg::POS_MAGIC_2: hdr_nxt.magic_ok = hdr_r.magic_ok &&
                                                  (header_byte == rihp_pkg::MAGIC_2);
        rihp_pkg::POS_MAGIC_3: hdr_nxt.magic_ok = hdr_r.magic_ok &&
                                                  (header_byte == rihp_pkg::MAGIC_3);
        rihp_pkg::POS_PRG:     hdr_nxt.prg_bank_count = header_byte;
        rihp_pkg::POS_CHR:     hdr_nxt.chr_bank_count = header_byte;
        rihp_pkg::POS_FLAGS6:  hdr_nxt.flags_six      = header_byte;
        rihp_pkg::POS_FLAGS7:  hdr_nxt.flags_seven    = header_byte;
        rihp_pkg::POS_RAM:     hdr_nxt.ram_bank_count = header_byte;
        rihp_pkg::POS_FORMAT:  hdr_nxt.format_byte    = header_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= rihp_pkg::POS_IDLE;
      hdr_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      hdr_r <= hdr_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rihp_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module rihp_decode (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rihp_pkg::hdr_t                  hdr,
  input  wire logic                            last_taken,
  output logic                                 can_load,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [rihp_pkg::RESULT_W-1:0]        out_tdata
);

  rihp_pkg::result_t res;
  rihp_pkg::result_t res_r;
  logic              valid_r;
  logic              valid_nxt;
  rihp_pkg::status_t status;
  logic [9:0]        prg_off;
  logic [21:0]       prg_bytes;

  // Status checks in priority order.
  always_comb begin
    if (!hdr.magic_ok) begin
      status = rihp_pkg::ST_BAD_MAGIC;
    end else if (hdr.format_byte != rihp_pkg::FORMAT_V1 &&
                 hdr.format_byte != rihp_pkg::FORMAT_V2) begin
      status = rihp_pkg::ST_BAD_FORMAT;
    end else if (hdr.format_byte == rihp_pkg::FORMAT_V2) begin
      status = rihp_pkg::ST_V2_UNSUPP;
    end else begin
      status = rihp_pkg::ST_OK;
    end
  end

  // Sizes are bank counts shifted into place; offsets add the trainer.
  assign prg_bytes = {hdr.prg_bank_count, 14'd0};
  assign prg_off   = rihp_pkg::HEADER_OFFSET |
                     (hdr.flags_six[rihp_pkg::F6_TRAINER] ? rihp_pkg::TRAINER_BYTES : 10'd0);

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == rihp_pkg::ST_OK) begin
      res.mapper_number  = {hdr.flags_seven[7:4], hdr.flags_six[7:4]};
      res.mirroring_mode = hdr.flags_six[rihp_pkg::F6_FOUR] ? rihp_pkg::MIR_FOUR :
                           (hdr.flags_six[rihp_pkg::F6_MIRROR] ? rihp_pkg::MIR_VERTICAL :
                                                                 rihp_pkg::MIR_HORIZONTAL);
      res.has_battery    = hdr.flags_six[rihp_pkg::F6_BATTERY];
      res.has_trainer    = hdr.flags_six[rihp_pkg::F6_TRAINER];
      res.prg_rom_bytes  = prg_bytes;
      res.chr_bytes      = (hdr.chr_bank_count == 8'd0) ? rihp_pkg::EIGHT_K :
                           {hdr.chr_bank_count, 13'd0};
      res.prg_ram_bytes  = (hdr.ram_bank_count == 8'd0) ? rihp_pkg::EIGHT_K :
                           {hdr.ram_bank_count, 13'd0};
      res.chr_is_ram     = (hdr.chr_bank_count == 8'd0);
      res.prg_offset     = prg_off;
      res.chr_offset     = {12'd0, prg_off} + prg_bytes;
    end
  end

  // Output register: loads when empty or being drained in the same cycle.
  assign can_load  = !valid_r || out_tready;
  assign valid_nxt = last_taken ? 1'b1 : (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (last_taken) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r;

endmodule

`default_nettype wire

/* hw/rtl/rom_image_header_parser_core_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module rom_image_header_parser_core_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [111:0] out_tdata
);

  // A stalled result item holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // A failed header carries nothing but its status.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != 2'd0) |-> (out_tdata[111:2] == 110'd0))
    else $error("failed header carries decoded fields");

  // Character data follows program data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == 2'd0) |->
      (out_tdata[110:89] == (22'(out_tdata[88:79]) + out_tdata[35:14])))
    else $error("chr_offset does not follow program data");

  // A good header never reports the unused mirroring code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == 2'd0) |-> (out_tdata[11:10] != 2'd3))
    else $error("invalid mirroring code");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rom_image_header_parser_core rom_image_header_parser_core_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
